// ----- rtl/wma_pkg.sv -----
// Shared constants and controller/datapath interface types for the moving average block.
`timescale 1ns / 1ps
package wma_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int HELD_W         = 5;
    localparam int WINDOW_DEFAULT = 20;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input sample
        logic read;     // read the ring slot about to be overwritten
        logic update;   // write ring, update sum, count and slot
        logic prep;     // load divider with rounded magnitude
        logic step;     // one restoring division step
        logic load;     // load result into output register
    } wma_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last; // current division step is the final one
    } wma_sts_t;

endpackage

// ----- rtl/warmup_moving_average_top.sv -----
// Top level of the moving average block with warm-up.
`timescale 1ns / 1ps
// Moving average of signed depth samples over the last WINDOW samples.
// Input channel s_*: one 16-bit signed sample per transfer. Result channel m_*:
// one transfer per sample, carrying the mean of the held samples, rounded half
// away from zero, and the number of samples held (grows 1..WINDOW, then stays).
// Timing: after an input transfer the controller steps through a ring read, a
// ring/sum update, a divider load, SUM_W restoring division steps (one quotient
// bit per cycle, SUM_W = 16 + clog2(WINDOW+1), 21 at WINDOW = 20) and a result
// load, which raises m_valid. The next sample is accepted only after that load;
// s_ready is low while a sample is being processed.
// The output register holds a finished result while m_ready is low; the next
// sample is accepted meanwhile, and its result waits in the deliver state until
// the output register is taken.
// Reset (aresetn low, synchronous): count, sum and write slot clear, m_valid
// drops and s_ready goes high. Ring contents are not cleared; an entry is only
// used after it has been written.
module warmup_moving_average_top #(
    parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] s_depth_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wma_pkg::SAMPLE_W-1:0] m_average_depth,
    output logic        [wma_pkg::HELD_W-1:0]   m_samples_held
);

    wma_pkg::wma_cmd_t cmd;
    wma_pkg::wma_sts_t sts;

    wma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    wma_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_depth_sample  (s_depth_sample),
        .m_average_depth (m_average_depth),
        .m_samples_held  (m_samples_held)
    );

endmodule

// ----- rtl/wma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/wma_ctrl.sv -----
// Controller state machine: sequences ring update, division and result handoff.
`timescale 1ns / 1ps
module wma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output wma_pkg::wma_cmd_t cmd,
    input  wma_pkg::wma_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_PREP,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                // output register free, or its transfer completes this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready_next = (state_next == ST_IDLE);
    assign m_valid_next = cmd.load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/wma_dp.sv -----
// Datapath: sample ring, running sum, held count and restoring divider.
`timescale 1ns / 1ps
module wma_dp #(
    parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wma_pkg::wma_cmd_t                   cmd,
    output wma_pkg::wma_sts_t                   sts,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] s_depth_sample,
    output logic signed [wma_pkg::SAMPLE_W-1:0] m_average_depth,
    output logic        [wma_pkg::HELD_W-1:0]   m_samples_held
);

    localparam int SW     = wma_pkg::SAMPLE_W;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SW + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    logic signed [SW-1:0]    sample_reg;
    logic signed [SW-1:0]    old_sample;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    full;

    logic [SUM_W-1:0]        num_reg, num_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    neg_reg;
    logic [SUM_W-1:0]        half;
    logic [CNT_W:0]          rem_shift;
    logic                    ge;
    logic [SW-1:0]           quo;
    logic signed [SW-1:0]    avg_reg;
    logic [wma_pkg::HELD_W-1:0] held_reg;

    wma_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .re    (cmd.read),
        .raddr (slot_reg),
        .rdata (old_sample)
    );

    // Ring update: oldest sample drops out only once the window is full
    assign full      = (cnt_reg == CNT_W'(WINDOW));
    assign sum_next  = sum_reg + SUM_W'(sample_reg) - (full ? SUM_W'(old_sample) : '0);
    assign cnt_next  = full ? cnt_reg : cnt_reg + 1'b1;
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end else if (cmd.update) begin
            slot_reg <= slot_next;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_depth_sample;
        end
    end

    // Rounding half away from zero: divide |sum| + count/2 by count
    assign half      = SUM_W'(cnt_reg >> 1);
    assign rem_shift = {rem_reg, num_reg[SUM_W-1]};
    assign ge        = (rem_shift >= {1'b0, cnt_reg});

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.prep) begin
            num_next  = sum_reg[SUM_W-1] ? (half - $unsigned(sum_reg))
                                         : ($unsigned(sum_reg) + half);
            rem_next  = '0;
            step_next = '0;
        end else if (cmd.step) begin
            num_next  = {num_reg[SUM_W-2:0], ge};
            rem_next  = ge ? CNT_W'(rem_shift - {1'b0, cnt_reg}) : CNT_W'(rem_shift);
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (cmd.prep) begin
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    assign sts.div_last = (step_reg == STEP_W'(SUM_W - 1));

    // Quotient magnitude never exceeds 32768, so 16 bits hold it before negation
    assign quo = num_reg[SW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            avg_reg  <= neg_reg ? (~quo + 1'b1) : quo;
            held_reg <= wma_pkg::HELD_W'(cnt_reg);
        end
    end

    assign m_average_depth = avg_reg;
    assign m_samples_held  = held_reg;

endmodule

// ----- rtl/wma_checker.sv -----
// Port-level checker for the moving average block, bound to the top level.
`timescale 1ns / 1ps
module wma_checker #(
    parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic signed [wma_pkg::SAMPLE_W-1:0] s_depth_sample,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [wma_pkg::SAMPLE_W-1:0] m_average_depth,
    input logic        [wma_pkg::HELD_W-1:0]   m_samples_held
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average_depth)
                                && $stable(m_samples_held))
        else $error("result changed while stalled");

    // one sample at a time: input closes right after a transfer
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // a result always covers at least one sample
    a_held_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_samples_held != '0) || (WINDOW > 31))
        else $error("result with no samples held");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind warmup_moving_average_top wma_checker #(.WINDOW(WINDOW)) u_wma_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for the moving average block with warm-up.
`timescale 1ns / 1ps
module tb;

    localparam int WINDOW      = wma_pkg::WINDOW_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_ITEMS  = 950;

    typedef logic signed [wma_pkg::SAMPLE_W-1:0] depth_t;

    typedef struct packed {
        logic signed [wma_pkg::SAMPLE_W-1:0] average_depth;
        logic [wma_pkg::HELD_W-1:0]          samples_held;
    } depth_result_t;

    logic   aclk           = 1'b0;
    logic   aresetn        = 1'b0;
    logic   s_valid        = 1'b0;
    logic   s_ready;
    depth_t s_depth_sample = '0;
    logic   m_valid;
    logic   m_ready        = 1'b0;
    depth_t m_average_depth;
    logic [wma_pkg::HELD_W-1:0] m_samples_held;

    warmup_moving_average_top #(.WINDOW(WINDOW)) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_depth_sample (s_depth_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average_depth(m_average_depth),
        .m_samples_held (m_samples_held)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state
    int            depth_ring [WINDOW];
    int            next_slot   = 0;
    int            depth_count = 0;
    int            depth_sum   = 0;

    depth_t        pending_samples [$];
    depth_result_t expected_means  [$];

    int mismatches    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int cycle_count   = 0;

    // Fold one sample into the window and return the rounded mean and count.
    function automatic depth_result_t fold_depth_sample(input depth_t sample);
        depth_result_t     res;
        int unsigned       mag;
        int unsigned       quo;
        if (depth_count >= WINDOW) begin
            depth_sum -= depth_ring[next_slot];
        end else begin
            depth_count++;
        end
        depth_ring[next_slot] = int'(sample);
        depth_sum += int'(sample);
        next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        mag = (depth_sum < 0) ? -depth_sum : depth_sum;
        quo = (mag + depth_count / 2) / depth_count;
        res.average_depth = depth_t'((depth_sum < 0) ? -int'(quo) : int'(quo));
        res.samples_held  = depth_count[wma_pkg::HELD_W-1:0];
        return res;
    endfunction

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_means.push_back(fold_depth_sample(s_depth_sample));
                samples_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                s_valid        <= 1'b1;
                s_depth_sample <= pending_samples.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: alternates between always ready, random and long stalls
    int ready_mode      = 0;
    int ready_mode_left = 0;

    always @(posedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(50, 400);
        end else begin
            ready_mode_left--;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Result checker
    always @(posedge aclk) begin
        depth_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_means.size() == 0) begin
                $error("Result transfer with no sample pending: avg %0d held %0d",
                       m_average_depth, m_samples_held);
                mismatches++;
            end else begin
                want = expected_means.pop_front();
                if (m_average_depth !== want.average_depth) begin
                    $error("average_depth: expected %0d, got %0d",
                           want.average_depth, m_average_depth);
                    mismatches++;
                end
                if (m_samples_held !== want.samples_held) begin
                    $error("samples_held: expected %0d, got %0d",
                           want.samples_held, m_samples_held);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int     n;
        int     run;
        int     kind;
        depth_t extreme;

        // Directed: extremes, rounding ties both signs, warm-up into wrap
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(-16'sh8000);   // sum -1 over 2 rounds to -1
        pending_samples.push_back(16'sd1);       // sum 0
        pending_samples.push_back(16'sd2);       // sum 2 over 4 rounds to 1
        repeat (21) pending_samples.push_back(-16'sh8000);

        n = 0;
        while (n < RAND_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                pending_samples.push_back(depth_t'($urandom_range(0, 65535)));
                n++;
            end else if (kind < 15) begin
                // saturating runs push the window sum to its limits
                extreme = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                run = $urandom_range(WINDOW, WINDOW + 10);
                repeat (run) pending_samples.push_back(extreme);
                n += run;
            end else if (kind < 18) begin
                // small values hit exact halves often
                run = $urandom_range(1, 8);
                repeat (run) pending_samples.push_back(depth_t'($signed($urandom_range(0, 6)) - 3));
                n += run;
            end else begin
                pending_samples.push_back(depth_t'($urandom_range(0, 1) ?
                    $urandom_range(65535 - 40, 65535) : $urandom_range(0, 40)));
                n++;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_samples.size() > 0 || s_valid || expected_means.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d depth samples and checked %0d averages through warm-up,",
                 samples_sent, results_seen);
        $display("ring wrap, saturated windows and rounding ties under random stalls.");
        if (mismatches == 0 && expected_means.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wma_pkg.sv
rtl/wma_ram.sv
rtl/wma_ctrl.sv
rtl/wma_dp.sv
rtl/warmup_moving_average_top.sv
rtl/wma_checker.sv
test/tb.sv
